// ===== hdl/dphp_pkg.sv =====
`default_nettype none

package dphp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ENABLE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] DECAY_ONE    = 17'd65536;
    localparam logic [CFG_DATA_W-1:0] DECAY_RESET  = 17'd62259;
    localparam logic [3:0]            ENABLE_RESET = 4'hF;

    // fixed field widths
    localparam int PIX_W   = 16;
    localparam int PLANE_W = 2;
    localparam int IDX_W   = 20;
    localparam int HIST_W  = 32;

    // result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = 4;

    // per-beat control that rides along the pipeline
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PLANE_W-1:0] plane;
        logic               byp;
        logic               en;
    } item_t;

    // unsigned 16.16 to integer, ties to even; history never exceeds 0xFFFF0000
    function automatic logic [PIX_W-1:0] round_half_even(input logic [HIST_W-1:0] h);
        logic [15:0] ip;
        logic [15:0] fr;
        logic        up;
        ip = h[31:16];
        fr = h[15:0];
        up = (fr > 16'h8000) || ((fr == 16'h8000) && ip[0]);
        return ip + {15'd0, up};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/decaying_peak_hold_pixel_top.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  -----------------------------------------
// in        sink       in_valid / in_stall    pixel_value, plane_index, pixel_index, bypass
// out       source     out_valid / out_stall  pixel_out
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Sustains one beat per clock while in_stall is low: each beat does one history
// read-modify-write through one read port and one write port of the history RAM.
// An input beat passes the position wrap registers (stages 1 and 2), the RAM read
// (stage 3), the multiply (stage 4) and the result queue before it shows on out_valid.
// After reset the history RAM is swept to zero, one entry a cycle, over all 4 << POS_W
// entries (4,194,304 at the default size); in_stall is high during the sweep.
// out_stall backs into an 8-beat result queue; in_stall rises when 8 beats are in
// flight or queued. cfg_ready is always high.

module decaying_peak_hold_pixel_top #(
    parameter int PLANE_PIXELS = 1048576,
    parameter int PIXEL_BITS   = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [dphp_pkg::PIX_W-1:0]        pixel_value,
    input  wire logic [dphp_pkg::PLANE_W-1:0]      plane_index,
    input  wire logic [dphp_pkg::IDX_W-1:0]        pixel_index,
    input  wire logic                              bypass,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [dphp_pkg::PIX_W-1:0]             pixel_out,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dphp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dphp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dphp_pkg::*;

    // RAM layout: {plane, position}; position field rounded up to a power of two
    localparam int POS_W     = (PLANE_PIXELS > 1) ? $clog2(PLANE_PIXELS) : 1;
    localparam int ADDR_W    = POS_W + PLANE_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam bit WRAP      = PLANE_PIXELS < (1 << IDX_W);

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

    // ---------------- configuration ----------------
    logic [CFG_DATA_W-1:0] decay_reg;
    logic [3:0]            enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            enable_reg <= ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DECAY_FACTOR:
                begin
                    decay_reg <= (cfg_data > DECAY_ONE) ? DECAY_ONE : cfg_data;
                end
                CFG_PLANE_ENABLE:
                begin
                    enable_reg <= cfg_data[3:0];
                end
            endcase
        end
    end

    // ---------------- clear sweep and flow control ----------------
    logic              clear_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [OQ_CNT_W-1:0] used_reg, used_next;
    logic              acc;
    logic              pop;

    assign in_stall = clear_reg || (used_reg == OQ_CNT_W'(OQ_DEPTH));
    assign acc      = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {ADDR_W{1'b1}})
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // beats accepted and not yet taken at the output
    assign used_next = used_reg + OQ_CNT_W'(acc) - OQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // ---------------- stages 1, 2: position wrap ----------------
    item_t            it1_reg, it2_reg;
    logic             v1_reg, v2_reg;
    logic [IDX_W-1:0] idx1_reg, idx2_reg;
    logic [POS_W-1:0] pos2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        it1_reg.pix   <= pixel_value & PIX_MASK;
        it1_reg.plane <= plane_index;
        it1_reg.byp   <= bypass;
        it1_reg.en    <= enable_reg[plane_index];
        idx1_reg      <= pixel_index;
        it2_reg       <= it1_reg;
        idx2_reg      <= idx1_reg;
    end

    generate
        if (WRAP)
        begin : g_wrap
            // idx mod N via reciprocal; the estimate is low by at most one
            localparam int               RECIP_SH = IDX_W + 1;
            localparam logic [RECIP_SH:0] RECIP   = (RECIP_SH + 1)'((1 << RECIP_SH) / PLANE_PIXELS);
            localparam logic [IDX_W-1:0] NPIX     = IDX_W'(PLANE_PIXELS);
            localparam int               PROD_W   = IDX_W + RECIP_SH + 1;

            logic [PROD_W-1:0] prod1_reg;
            logic [IDX_W-1:0]  quo1;
            logic [IDX_W-1:0]  qn2_reg;
            logic [IDX_W:0]    rem2;
            logic [IDX_W:0]    rem2_fix;

            always_ff @(posedge clk)
            begin
                prod1_reg <= PROD_W'(pixel_index) * PROD_W'(RECIP);
                qn2_reg   <= IDX_W'((2 * IDX_W)'(quo1) * (2 * IDX_W)'(NPIX));
            end

            assign quo1     = prod1_reg[RECIP_SH +: IDX_W];
            assign rem2     = {1'b0, idx2_reg} - {1'b0, qn2_reg};
            assign rem2_fix = (rem2 >= {1'b0, NPIX}) ? rem2 - {1'b0, NPIX} : rem2;
            assign pos2     = POS_W'(rem2_fix);
        end
        else
        begin : g_nowrap
            assign pos2 = POS_W'(idx2_reg);
        end
    endgenerate

    // ---------------- history RAM ----------------
    logic [HIST_W-1:0] hist_mem [MEM_DEPTH];
    logic [ADDR_W-1:0] rd_addr;

    // stage 3: read data, stage 4: decayed product
    item_t             it3_reg, it4_reg;
    logic              v3_reg, v4_reg;
    logic [ADDR_W-1:0] addr3_reg, addr4_reg;
    logic [HIST_W-1:0] rdata3_reg;
    logic              fwd3_reg;
    logic [HIST_W-1:0] fwd_data3_reg;
    logic [HIST_W-1:0] hist3;
    logic [HIST_W-1:0] dec4_reg;
    logic [HIST_W-1:0] fresh4;
    logic [HIST_W-1:0] hv4;
    logic              wr4;
    logic [PIX_W-1:0]  res4;

    assign rd_addr = {it2_reg.plane, pos2};

    // stage 4 item: new history and write enable
    assign fresh4 = {it4_reg.pix, 16'h0000};
    assign hv4    = (fresh4 > dec4_reg) ? fresh4 : dec4_reg;
    assign wr4    = v4_reg && it4_reg.en;

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            hist_mem[clr_cnt_reg] <= '0;
        end
        else if (wr4)
        begin
            hist_mem[addr4_reg] <= hv4;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata3_reg    <= hist_mem[rd_addr];
        // write landing in the same cycle as the read: RAM returns old data
        fwd3_reg      <= wr4 && (addr4_reg == rd_addr);
        fwd_data3_reg <= hv4;
        it3_reg       <= it2_reg;
        addr3_reg     <= rd_addr;
    end

    // newest copy wins: item one ahead, then the one two ahead, then RAM
    always_comb
    begin
        priority if (wr4 && (addr4_reg == addr3_reg))
        begin
            hist3 = hv4;
        end
        else if (fwd3_reg)
        begin
            hist3 = fwd_data3_reg;
        end
        else
        begin
            hist3 = rdata3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dec4_reg  <= HIST_W'((49'(hist3) * 49'(decay_reg)) >> 16);
        it4_reg   <= it3_reg;
        addr4_reg <= addr3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign res4 = (it4_reg.en && !it4_reg.byp) ? round_half_even(hv4) : it4_reg.pix;

    // ---------------- result queue ----------------
    logic [PIX_W-1:0]    oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CNT_W-1:0] oq_cnt_reg, oq_cnt_next;

    assign oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(v4_reg) - OQ_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            oq_mem[oq_wr_reg] <= res4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_cnt_reg <= oq_cnt_next;
            if (v4_reg)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
        end
    end

    assign out_valid = (oq_cnt_reg != '0);
    assign pixel_out = oq_mem[oq_rd_reg];

endmodule

`default_nettype wire

// ===== tb/tb_decaying_peak_hold_pixel_top.sv =====
module tb_decaying_peak_hold_pixel_top;

    import dphp_pkg::*;

    // The history RAM is swept clear after reset (4 << 20 entries, one a cycle).
    // The limit covers that sweep plus several times the slowest item traffic.
    localparam int unsigned SWEEP_CYCLES = 32'd4_194_304;
    localparam int unsigned CYCLE_LIMIT  = SWEEP_CYCLES + 32'd600_000;
    // the pause after draining is longer than the path from input beat to out_valid
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASES        = 8;
    localparam int          PHASE_BEATS   = 170;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the per-pixel history and the registers,
    // predicts pixel_out for every accepted input beat.
    // ------------------------------------------------------------------
    class peak_hold_scoreboard;
        bit [31:0] history [bit [21:0]];    // sparse; absent entries read as zero
        bit [16:0] decay;
        bit [3:0]  enable;
        bit [15:0] pending_pixels [$];
        int        errors;

        function new();
            decay  = DECAY_RESET;
            enable = ENABLE_RESET;
            errors = 0;
        endfunction

        function void apply_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == CFG_DECAY_FACTOR)
                decay = (data > DECAY_ONE) ? DECAY_ONE : data;   // above 1.0 clamps
            else if (idx == CFG_PLANE_ENABLE)
                enable = data[3:0];
        endfunction

        // add just under a half on even integers, a full half on odd ones,
        // so exact ties land on the even neighbor
        function bit [15:0] round_to_even(bit [31:0] h);
            bit [32:0] sum;
            sum = {1'b0, h} + 33'h7FFF + {32'd0, h[16]};
            return sum[31:16];
        endfunction

        function void note_pixel(bit [15:0] pix, bit [1:0] plane, bit [19:0] pos, bit byp);
            bit [21:0] addr;
            bit [31:0] old;
            bit [48:0] prod;
            bit [31:0] decayed;
            bit [31:0] fresh;
            bit [31:0] peak;
            bit [15:0] res;
            addr = {plane, pos};
            res  = pix;
            if (enable[plane])
            begin
                old     = history.exists(addr) ? history[addr] : 32'd0;
                prod    = old * decay;
                decayed = prod[47:16];
                fresh   = {pix, 16'h0000};
                peak    = (fresh > decayed) ? fresh : decayed;
                history[addr] = peak;
                if (!byp)
                    res = round_to_even(peak);
            end
            pending_pixels.push_back(res);
        endfunction

        function void check_result(bit [15:0] got);
            bit [15:0] want;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel_out expected none, actual %04h", $time, got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got !== want)
            begin
                $display("%0t: pixel_out expected %04h, actual %04h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals; every input known from time zero.
    // ------------------------------------------------------------------
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_value = '0;
    logic [PLANE_W-1:0]    plane_index = '0;
    logic [IDX_W-1:0]      pixel_index = '0;
    logic                  bypass      = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // both sides may idle; cleared for the final phase
    bit                    idling      = 1'b1;
    int                    stall_left  = 0;

    peak_hold_scoreboard   sb = new();

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    decaying_peak_hold_pixel_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .plane_index (plane_index),
        .pixel_index (pixel_index),
        .bypass      (bypass),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Drivers. All of them are entered and left at a falling edge;
    // handshakes are sampled right after the rising edge, before the
    // DUT's registers update.
    // ------------------------------------------------------------------

    // One input beat, with an optional idle burst ahead of it. Valid stays
    // high on return so back-to-back beats run without a gap.
    task automatic send_pixel(input logic [15:0] pix, input logic [1:0] plane,
                              input logic [19:0] pos, input logic byp);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= pix;
        plane_index <= plane;
        pixel_index <= pos;
        bypass      <= byp;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(pix, plane, pos, byp);
        @(negedge clk);
    endtask

    // Register write; only called with the pipeline drained.
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected beat, then let the pipe go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random stall bursts, none in the last phase.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 3) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(pixel_out);
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [19:0]           hot_pos [16];
        logic [CFG_DATA_W-1:0] decay_set [PHASES];
        logic [3:0]            enable_set [PHASES];
        logic [15:0]           pix;
        logic [19:0]           pos;
        int unsigned           pick;

        // a small pool of positions so most beats revisit a pixel's history
        hot_pos[0] = 20'h00000;
        hot_pos[1] = 20'hFFFFF;
        for (int i = 2; i < 16; i++)
            hot_pos[4'(i)] = 20'($urandom_range(0, 20'hFFFFF));

        // per-phase settings: no decay, full decay, clamped above one,
        // just under one, tiny, the reset value and two random ones
        decay_set  = '{17'd65536, 17'd0, 17'h1FFFF, 17'd65535,
                       17'd1, 17'd62259, 17'd0, 17'd0};
        enable_set = '{4'hF, 4'hF, 4'b1010, 4'h0, 4'b0101, 4'hF, 4'h0, 4'hF};
        decay_set[6]  = 17'($urandom_range(0, 17'h1FFFF));
        decay_set[7]  = 17'($urandom_range(60000, 65536));
        enable_set[6] = 4'($urandom_range(0, 15));

        // hold reset, then release it; DUT then sweeps its RAM with in_stall high
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed: reset registers (decay about 0.95, all planes on) ----
        send_pixel(16'hFFFF, 2'd0, 20'h00000, 1'b0);    // full scale in
        send_pixel(16'h0000, 2'd0, 20'h00000, 1'b0);    // first decay step
        send_pixel(16'h0000, 2'd0, 20'h00000, 1'b1);    // bypass: raw out, history moves
        send_pixel(16'h0000, 2'd0, 20'h00000, 1'b0);    // shows bypass still decayed it
        send_pixel(16'hFFFF, 2'd3, 20'hFFFFF, 1'b0);    // last plane, last position
        send_pixel(16'h1234, 2'd3, 20'hFFFFF, 1'b1);
        send_pixel(16'h0000, 2'd3, 20'hFFFFF, 1'b0);
        send_pixel(16'h5555, 2'd1, 20'hAAAAA, 1'b0);
        send_pixel(16'hAAAA, 2'd2, 20'h55555, 1'b0);
        settle();

        // ---- directed: decay 0.5 so halves land exactly on ties ----
        program_reg(CFG_DECAY_FACTOR, 17'd32768);
        send_pixel(16'h0001, 2'd1, 20'h00007, 1'b0);
        send_pixel(16'h0000, 2'd1, 20'h00007, 1'b0);    // 0.5 -> 0 (even)
        send_pixel(16'h0003, 2'd1, 20'h00007, 1'b0);
        send_pixel(16'h0000, 2'd1, 20'h00007, 1'b0);    // 1.5 -> 2 (even)
        send_pixel(16'h0000, 2'd1, 20'h00007, 1'b0);    // 0.75 -> 1
        settle();

        // ---- directed: decay above one clamps, planes 1 and 3 disabled ----
        program_reg(CFG_DECAY_FACTOR, 17'h1FFFF);
        program_reg(CFG_PLANE_ENABLE, 4'b0101);
        send_pixel(16'h0100, 2'd0, 20'h00000, 1'b0);
        send_pixel(16'h0000, 2'd0, 20'h00000, 1'b0);    // held, never grows
        send_pixel(16'h0077, 2'd1, 20'h00007, 1'b0);    // pass-through, history kept
        send_pixel(16'h0009, 2'd3, 20'hFFFFF, 1'b1);
        settle();
        program_reg(CFG_PLANE_ENABLE, 4'hF);
        send_pixel(16'h0000, 2'd1, 20'h00007, 1'b0);    // still the old 0.75
        send_pixel(16'hFFFF, 2'd2, 20'hFFFFF, 1'b0);
        settle();

        // ---- random phases ----
        for (int p = 0; p < PHASES; p++)
        begin
            idling = (p != PHASES - 1);
            program_reg(CFG_DECAY_FACTOR, decay_set[3'(p)]);
            program_reg(CFG_PLANE_ENABLE, enable_set[3'(p)]);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    pix = 16'($urandom_range(0, 16'hFFFF));
                else if (pick < 7)
                    pix = 16'($urandom_range(0, 255));
                else if (pick < 9)
                    pix = 16'h0000;                     // let the decay run
                else
                    pix = 16'hFFFF;
                pos = ($urandom_range(0, 6) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                                  : hot_pos[4'($urandom_range(0, 15))];
                send_pixel(pix, 2'($urandom_range(0, 3)), pos, ($urandom_range(0, 7) == 0));
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_pixels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dphp_pkg.sv
hdl/decaying_peak_hold_pixel_top.sv
tb/tb_decaying_peak_hold_pixel_top.sv
